FILE: rtl/core/ivc_pkg.sv
// Package for the irrigation valve controller: shared types, codes and reset constants.
// Used by ivc_step and irrigation_valve_controller; depends on nothing.

package ivc_pkg;

    localparam int CNT_W = 24;

    localparam logic [1:0] ACT_FLOW     = 2'd0;
    localparam logic [1:0] ACT_CHECK    = 2'd1;
    localparam logic [1:0] ACT_MAINT    = 2'd2;
    localparam logic [1:0] ACT_REPORT   = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ALARM     = 3'd1;
    localparam logic [2:0] EV_START     = 3'd2;
    localparam logic [2:0] EV_END       = 3'd3;
    localparam logic [2:0] EV_REPORT    = 3'd4;

    localparam logic [2:0] REG_WINDOW_START = 3'd0;
    localparam logic [2:0] REG_WINDOW_END   = 3'd1;
    localparam logic [2:0] REG_VOLUME_LIMIT = 3'd2;
    localparam logic [2:0] REG_MAX_PULSES   = 3'd3;
    localparam logic [2:0] REG_MAINT_LIMIT  = 3'd4;

    localparam logic [16:0] WINDOW_START_RST = 17'd72000;
    localparam logic [16:0] WINDOW_END_RST   = 17'd72300;
    localparam logic [15:0] VOLUME_LIMIT_RST = 16'd500;
    localparam logic [15:0] MAX_PULSES_RST   = 16'd50;
    localparam logic [15:0] MAINT_LIMIT_RST  = 16'd1200;

    localparam logic [25:0] MS_PER_SEC = 26'd1000;

    typedef struct packed {
        logic [16:0] window_start_sec;
        logic [16:0] window_end_sec;
        logic [15:0] volume_limit;
        logic [15:0] max_pulses_per_read;
        logic [15:0] maintenance_limit_sec;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] pulses;
        logic [16:0] time_of_day_sec;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic             valve_state;
        logic             alarm_latched;
        logic             maintenance_active;
        logic [31:0]      maintenance_start_ms;
        logic [31:0]      session_start_ms;
        logic [31:0]      last_read_ms;
        logic [CNT_W-1:0] session_pulses;
        logic [CNT_W-1:0] report_pulses;
        logic [31:0]      report_interval_ms;
    } state_t;

    typedef struct packed {
        logic             valve_open;
        logic [2:0]       event_kind;
        logic [CNT_W-1:0] event_count;
        logic [31:0]      event_time_ms;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_add_cnt(input logic [CNT_W-1:0] a,
                                                      input logic [15:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W - 15){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/ivc_step.sv
// Event logic of the irrigation valve controller: next state and result for one word.
// Purely combinational; depends on ivc_pkg.

module ivc_step
    import ivc_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  st,
    input  item_t   item,
    output state_t  st_next,
    output result_t res_next
);

    logic [31:0] read_dt;
    logic [32:0] interval_sum;
    logic [31:0] maint_elapsed;
    logic [25:0] maint_limit_ms;
    logic        maint_expired;
    logic        in_window;
    logic        was_on;
    logic [31:0] session_len;

    assign read_dt        = item.time_ms - st.last_read_ms;
    assign interval_sum   = {1'b0, st.report_interval_ms} + {1'b0, read_dt};
    assign maint_elapsed  = item.time_ms - st.maintenance_start_ms;
    assign maint_limit_ms = 26'(cfg.maintenance_limit_sec) * MS_PER_SEC;
    assign maint_expired  = maint_elapsed >= {6'b0, maint_limit_ms};
    assign in_window      = (item.time_of_day_sec > cfg.window_start_sec)
                         && (item.time_of_day_sec < cfg.window_end_sec);
    assign was_on         = st.valve_state;
    assign session_len    = item.time_ms - st.session_start_ms;

    always_comb begin
        st_next                = st;
        res_next.event_kind    = EV_NONE;
        res_next.event_count   = '0;
        res_next.event_time_ms = '0;
        unique case (item.action)
            ACT_FLOW: begin
                st_next.report_interval_ms = interval_sum[32] ? 32'hFFFF_FFFF
                                                              : interval_sum[31:0];
                st_next.last_read_ms   = item.time_ms;
                st_next.session_pulses = sat_add_cnt(st.session_pulses, item.pulses);
                st_next.report_pulses  = sat_add_cnt(st.report_pulses, item.pulses);
                if (st.valve_state && !st.alarm_latched
                        && item.pulses > cfg.max_pulses_per_read) begin
                    st_next.alarm_latched = 1'b1;
                    st_next.valve_state   = 1'b0;
                    res_next.event_kind   = EV_ALARM;
                    res_next.event_count  = {{(CNT_W - 16){1'b0}}, item.pulses};
                end
            end
            ACT_CHECK: begin
                if (st.maintenance_active) begin
                    if (maint_expired) begin
                        st_next.maintenance_active = 1'b0;
                        st_next.valve_state        = 1'b0;
                    end else begin
                        st_next.valve_state = 1'b1;
                    end
                end else if (in_window) begin
                    st_next.valve_state = !st.alarm_latched
                        && (st.session_pulses < {{(CNT_W - 16){1'b0}}, cfg.volume_limit});
                end else begin
                    if (was_on && !st.alarm_latched) begin
                        res_next.event_kind    = EV_END;
                        res_next.event_count   = st.session_pulses;
                        res_next.event_time_ms = session_len;
                    end
                    st_next.valve_state        = 1'b0;
                    st_next.session_pulses     = '0;
                    st_next.report_interval_ms = '0;
                    st_next.alarm_latched      = 1'b0;
                end
                if (!was_on && st_next.valve_state) begin
                    st_next.session_start_ms = item.time_ms;
                    res_next.event_kind      = EV_START;
                    res_next.event_count     = '0;
                    res_next.event_time_ms   = '0;
                end else if (was_on && !st_next.valve_state && !st_next.alarm_latched
                        && in_window) begin
                    res_next.event_kind    = EV_END;
                    res_next.event_count   = st.session_pulses;
                    res_next.event_time_ms = session_len;
                end
            end
            ACT_MAINT: begin
                st_next.maintenance_active   = 1'b1;
                st_next.maintenance_start_ms = item.time_ms;
            end
            ACT_REPORT: begin
                if (st.report_pulses != '0) begin
                    res_next.event_kind        = EV_REPORT;
                    res_next.event_count       = st.report_pulses;
                    res_next.event_time_ms     = st.report_interval_ms;
                    st_next.report_pulses      = '0;
                    st_next.report_interval_ms = '0;
                end
            end
            default: begin
            end
        endcase
        res_next.valve_open = st_next.valve_state;
    end

endmodule

FILE: rtl/core/irrigation_valve_controller.sv
// Irrigation valve controller top level: input register, event logic, result register.
// Each word passes the input register and then the result register; a result that is not
// taken stalls the input. One word is accepted every cycle while results are taken; the
// event logic sits between the input register and the result register. Synchronous
// active-low reset clears the valid flags and all controller state and loads the
// configuration registers with their default values. Depends on ivc_pkg and ivc_step.

module irrigation_valve_controller
    import ivc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_pulses,
    input  logic [16:0] s_time_of_day_sec,
    input  logic [31:0] s_time_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valve_open,
    output logic [2:0]  m_event_kind,
    output logic [23:0] m_event_count,
    output logic [31:0] m_event_time_ms
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    fire;

    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_start_sec      <= WINDOW_START_RST;
            cfg_reg.window_end_sec        <= WINDOW_END_RST;
            cfg_reg.volume_limit          <= VOLUME_LIMIT_RST;
            cfg_reg.max_pulses_per_read   <= MAX_PULSES_RST;
            cfg_reg.maintenance_limit_sec <= MAINT_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WINDOW_START: cfg_reg.window_start_sec      <= cfg_data;
                REG_WINDOW_END:   cfg_reg.window_end_sec        <= cfg_data;
                REG_VOLUME_LIMIT: cfg_reg.volume_limit          <= cfg_data[15:0];
                REG_MAX_PULSES:   cfg_reg.max_pulses_per_read   <= cfg_data[15:0];
                REG_MAINT_LIMIT:  cfg_reg.maintenance_limit_sec <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.action          <= s_action;
            item_reg.pulses          <= s_pulses;
            item_reg.time_of_day_sec <= s_time_of_day_sec;
            item_reg.time_ms         <= s_time_ms;
        end
    end

    ivc_step u_step (
        .cfg      (cfg_reg),
        .st       (state_reg),
        .item     (item_reg),
        .st_next  (state_next),
        .res_next (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_valve_open    = res_reg.valve_open;
    assign m_event_kind    = res_reg.event_kind;
    assign m_event_count   = res_reg.event_count;
    assign m_event_time_ms = res_reg.event_time_ms;

endmodule
